// File: design/assert_macros.svh
// Assertion macros included by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/cfd_pkg.sv
// Types and constants of the COBS frame decoder
package cfd_pkg;

    // Result kinds carried on m_tuser
    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_EMPTY      = 2'd1,
        KIND_INCOMPLETE = 2'd2,
        KIND_UNEXPECTED = 2'd3
    } kind_t;

    localparam int          BYTE_W      = 8;
    localparam int          LEN_W       = 6;
    localparam int          MODE_W      = 2;
    localparam int          TDATA_W     = 16;
    localparam logic [7:0]  FRAME_DELIM = 8'h00;

endpackage

// File: design/cobs_frame_decoder_unit.sv
// COBS frame decoder: byte-serial unstuffing of framed packets
//
// Takes one received byte per cycle on the s_ channel and gives at most one
// result per byte on the m_ channel, registered, in the cycle after acceptance.
// A 0x00 byte opens a frame (reporting an incomplete frame if one was open);
// the next byte is a header with the mode in bits 7..6 and the body length in
// bits 5..0 (zero length waits for another header). The body is unstuffed on
// the fly: the opening code byte gives nothing, each later body byte gives
// its value or a zero where it is a code byte, and the final one is flagged
// on m_tlast. A one-byte body gives an empty-frame marker. Nonzero bytes
// outside a frame come back as unexpected-byte errors. Throughput is one byte
// every cycle; the only limit is the single result register, which takes a
// new result in the cycle its current one is taken downstream.
module cobs_frame_decoder_unit
    import cfd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [7:0] data, [9:8] mode, [15:10] zero
    output logic [1:0]          m_tuser,   // [1:0] kind
    output logic                m_tlast    // last
);

`include "assert_macros.svh"

    // Decoder state
    logic               in_frame_reg,      in_frame_next;
    logic               header_taken_reg,  header_taken_next;
    logic [LEN_W-1:0]   body_length_reg,   body_length_next;
    logic [LEN_W-1:0]   body_position_reg, body_position_next;
    logic [BYTE_W-1:0]  run_left_reg,      run_left_next;
    logic [MODE_W-1:0]  frame_mode_reg,    frame_mode_next;

    // Result register
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [BYTE_W-1:0]  out_data_reg;
    logic [MODE_W-1:0]  out_mode_reg;
    logic               out_last_reg;

    // Result of the current request
    logic               res_valid;
    kind_t              res_kind;
    logic [BYTE_W-1:0]  res_data;
    logic [MODE_W-1:0]  res_mode;
    logic               res_last;

    logic               accept;
    logic               is_last;
    logic [LEN_W:0]     pos_plus_one;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_plus_one = {1'b0, body_position_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign is_last      = pos_plus_one >= {1'b0, body_length_reg};

    // Decode one byte against the frame state
    always_comb begin
        in_frame_next      = in_frame_reg;
        header_taken_next  = header_taken_reg;
        body_length_next   = body_length_reg;
        body_position_next = body_position_reg;
        run_left_next      = run_left_reg;
        frame_mode_next    = frame_mode_reg;
        res_valid          = 1'b0;
        res_kind           = KIND_DATA;
        res_data           = '0;
        res_mode           = '0;
        res_last           = 1'b0;

        if (s_tdata == FRAME_DELIM) begin
            // open a fresh frame, flag the one left open
            in_frame_next      = 1'b1;
            header_taken_next  = 1'b0;
            body_length_next   = '0;
            body_position_next = '0;
            run_left_next      = '0;
            if (in_frame_reg) begin
                res_valid = 1'b1;
                res_kind  = KIND_INCOMPLETE;
            end
        end else if (!in_frame_reg) begin
            res_valid = 1'b1;
            res_kind  = KIND_UNEXPECTED;
            res_data  = s_tdata;
        end else if (!header_taken_reg) begin
            // take the header; zero length waits for another
            frame_mode_next    = s_tdata[BYTE_W-1 -: MODE_W];
            body_length_next   = s_tdata[LEN_W-1:0];
            body_position_next = '0;
            header_taken_next  = (s_tdata[LEN_W-1:0] != '0);
        end else if (body_position_reg == '0) begin
            // opening code byte
            run_left_next = s_tdata;
            if (body_length_reg == LEN_W'(1)) begin
                res_valid          = 1'b1;
                res_kind           = KIND_EMPTY;
                res_mode           = frame_mode_reg;
                res_last           = 1'b1;
                in_frame_next      = 1'b0;
                header_taken_next  = 1'b0;
                body_length_next   = '0;
                body_position_next = '0;
                run_left_next      = '0;
            end else begin
                body_position_next = LEN_W'(1);
            end
        end else begin
            // data byte inside a run, or a code byte that stands for zero
            res_valid = 1'b1;
            res_kind  = KIND_DATA;
            res_mode  = frame_mode_reg;
            if (run_left_reg > BYTE_W'(1)) begin
                res_data      = s_tdata;
                run_left_next = run_left_reg - BYTE_W'(1);
            end else begin
                res_data      = '0;
                run_left_next = s_tdata;
            end
            if (is_last) begin
                res_last           = 1'b1;
                in_frame_next      = 1'b0;
                header_taken_next  = 1'b0;
                body_length_next   = '0;
                body_position_next = '0;
                run_left_next      = '0;
            end else begin
                body_position_next = pos_plus_one[LEN_W-1:0];
            end
        end
    end

    // Advance the frame state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg      <= 1'b0;
            header_taken_reg  <= 1'b0;
            body_length_reg   <= '0;
            body_position_reg <= '0;
            run_left_reg      <= '0;
            frame_mode_reg    <= '0;
        end else if (accept) begin
            in_frame_reg      <= in_frame_next;
            header_taken_reg  <= header_taken_next;
            body_length_reg   <= body_length_next;
            body_position_reg <= body_position_next;
            run_left_reg      <= run_left_next;
            frame_mode_reg    <= frame_mode_next;
        end
    end

    // Hold the result until taken, load a new one as the old one leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
            out_mode_reg <= res_mode;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-BYTE_W-MODE_W){1'b0}}, out_mode_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Consistency of the frame state and the results
    `ASSERT_CLK(a_header_in_frame, header_taken_reg |-> in_frame_reg, "header taken outside a frame")
    `ASSERT_CLK(a_header_length, header_taken_reg |-> (body_length_reg != '0), "zero length header kept")
    `ASSERT_CLK(a_body_after_header, (body_position_reg != '0) |-> header_taken_reg, "body position without header")
    `ASSERT_CLK(a_error_fields, (m_tvalid && (out_kind_reg == KIND_INCOMPLETE || out_kind_reg == KIND_UNEXPECTED)) |-> (!m_tlast && out_mode_reg == '0), "error result carries frame fields")
    `ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !out_valid_reg, "result valid after reset")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the COBS frame decoder unit
module tb_top;
    import cfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int TAIL_CYCLES    = 10;
    localparam int PAD_W          = TDATA_W - BYTE_W - MODE_W;

    // One decoder result, split into its fields
    typedef struct {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic [MODE_W-1:0]  mode;
        logic               last;
        logic [PAD_W-1:0]   pad;
    } cobs_result_t;

    // Unstuffing predictor and store of expected results
    class cobs_scoreboard;
        bit                 frame_open;
        bit                 have_header;
        bit [LEN_W-1:0]     body_len;
        bit [LEN_W-1:0]     body_pos;
        bit [BYTE_W-1:0]    run_count;
        bit [MODE_W-1:0]    cur_mode;
        cobs_result_t       expected_q[$];
        int                 mismatches;

        function new();
            close_frame();
            cur_mode   = '0;
            mismatches = 0;
        endfunction

        function void close_frame();
            frame_open  = 0;
            have_header = 0;
            body_len    = '0;
            body_pos    = '0;
            run_count   = '0;
        endfunction

        function void push_result(kind_t k, logic [BYTE_W-1:0] d, logic [MODE_W-1:0] m,
                                  logic l);
            cobs_result_t r;
            r.kind = k;
            r.data = d;
            r.mode = m;
            r.last = l;
            r.pad  = '0;
            expected_q.push_back(r);
        endfunction

        // Advance the decoder state by one accepted byte
        function void note_request(logic [BYTE_W-1:0] rx);
            bit                 was_open;
            bit                 is_last;
            logic [BYTE_W-1:0]  value;
            if (rx == FRAME_DELIM) begin
                was_open = frame_open;
                close_frame();
                frame_open = 1;
                if (was_open)
                    push_result(KIND_INCOMPLETE, '0, '0, 1'b0);
            end else if (!frame_open) begin
                push_result(KIND_UNEXPECTED, rx, '0, 1'b0);
            end else if (!have_header) begin
                cur_mode    = rx[7:6];
                body_len    = rx[5:0];
                body_pos    = '0;
                have_header = (body_len != 0);
            end else if (body_pos == 0) begin
                // Opening code byte; a one-byte body is an empty frame
                run_count = rx;
                if (body_len == 1) begin
                    push_result(KIND_EMPTY, '0, cur_mode, 1'b1);
                    close_frame();
                end else begin
                    body_pos = 1;
                end
            end else begin
                is_last = (int'(body_pos) + 1 >= int'(body_len));
                if (run_count > 1) begin
                    value     = rx;
                    run_count = run_count - 1;
                end else begin
                    value     = '0;
                    run_count = rx;
                end
                push_result(KIND_DATA, value, cur_mode, is_last);
                if (is_last)
                    close_frame();
                else
                    body_pos = body_pos + 1;
            end
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(cobs_result_t got);
            cobs_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none expected: kind %0d data %h mode %0d last %0d",
                             $realtime, got.kind, got.data, got.mode, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data || got.mode !== want.mode ||
                got.last !== want.last || got.pad !== want.pad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected kind %0d data %h mode %0d last %0d pad %h, got kind %0d data %h mode %0d last %0d pad %h",
                             $realtime, want.kind, want.data, want.mode, want.last, want.pad,
                             got.kind, got.data, got.mode, got.last, got.pad);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;    // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;    // [7:0] data, [9:8] mode, [15:10] zero
    logic [1:0]          m_tuser;    // [1:0] kind
    logic                m_tlast;

    cobs_scoreboard sb = new();

    int send_idle;
    int recv_idle;
    int hold_req;
    int sent_count;
    int stall_cycles;

    cobs_frame_decoder_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver: random stalls, plus a long hold whenever one is requested
    initial begin
        int hold_seen;
        hold_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_seen + 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Monitor both channels and watch for a hung handshake
    always @(posedge aclk) begin
        cobs_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready) begin
                got.kind = kind_t'(m_tuser);
                got.data = m_tdata[BYTE_W-1:0];
                got.mode = m_tdata[BYTE_W+MODE_W-1:BYTE_W];
                got.last = m_tlast;
                got.pad  = m_tdata[TDATA_W-1:BYTE_W+MODE_W];
                sb.check_result(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Offer one byte, idling at random first, and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= BYTE_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // Stop offering and wait until every expected result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted byte first
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // One frame with stuffed body; some frames carry noise, a zero-length header or are cut short
    task automatic send_frame();
        int choice;
        int len;
        int cut;
        int rem;
        int code;
        choice = $urandom_range(99);
        if (choice < 8)
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(FRAME_DELIM);
        if (choice >= 8 && choice < 12)
            send_byte({MODE_W'($urandom_range(3)), LEN_W'(0)});
        len = ($urandom_range(99) < 5) ? $urandom_range(32, 63) : $urandom_range(1, 8);
        send_byte({MODE_W'($urandom_range(3)), LEN_W'(len)});
        cut = (choice >= 12 && choice < 20) ? $urandom_range(0, len - 1) : len;
        rem = 0;
        for (int i = 0; i < cut; i++) begin
            if (rem == 0) begin
                code = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
                send_byte(BYTE_W'(code));
                rem = code - 1;
            end else begin
                send_byte(BYTE_W'($urandom_range(1, 255)));
                rem--;
            end
        end
    endtask

    task automatic run_frames(input int count);
        int target;
        target = sent_count + count;
        while (sent_count < target) send_frame();
    endtask

    // Stimulus
    initial begin
        logic [BYTE_W-1:0] directed[];
        directed = '{
            8'hFF, 8'h01,                       // bytes outside a frame
            8'h00, 8'hC0, 8'h41, 8'h37,         // zero-length header, then empty frame
            8'h00, 8'h00,                       // delimiter before any header
            8'h85, 8'h03, 8'hAA, 8'hBB, 8'h01, 8'h01,  // code of one ends the frame
            8'h7E,                              // byte after frame end
            8'h00, 8'h3F, 8'hFF, 8'hFF, 8'h80,  // longest body, cut short
            8'h00, 8'hC2, 8'h01, 8'hFE,
            8'h00, 8'h42, 8'h05, 8'h10
        };
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        hold_req     <= 0;
        recv_idle    <= 81;
        send_idle    = 11;
        sent_count   = 0;
        stall_cycles <= 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_byte(directed[i]);
        run_frames(410);
        drain();

        // Swap idling; hold the receiver off while frames keep coming
        send_idle = 81;
        recv_idle <= 11;
        hold_req  <= hold_req + 1;
        repeat (4) send_frame();
        run_frames(400);
        drain();

        send_idle = 0;
        recv_idle <= 0;
        run_frames(430);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/cfd_pkg.sv
design/cobs_frame_decoder_unit.sv
dv/tb_top.sv
